/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spta_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse polynomial term accumulator package
// Sizes, codes and transaction types shared by the accumulator modules.
// ----------------------------------------------------------------------------
package spta_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int IDX_W       = $clog2(MAX_TERMS);
  localparam int CNT_W       = $clog2(MAX_TERMS + 1);
  localparam int EXP_IN_W    = 15;
  localparam int EXP_W       = 16;
  localparam int COEFF_W     = 32;
  localparam int TCOUNT_W    = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_TERM = 2'd1,
    OP_ADD_PROD = 2'd2,
    OP_DUMP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                        operation;
    logic [EXP_IN_W-1:0]        exp_a;
    logic signed [COEFF_W-1:0]  coeff_a;
    logic [EXP_IN_W-1:0]        exp_b;
    logic signed [COEFF_W-1:0]  coeff_b;
  } term_req_t;

  typedef struct packed {
    logic [EXP_W-1:0]           out_exp;
    logic signed [COEFF_W-1:0]  out_coeff;
    logic [TCOUNT_W-1:0]        term_count;
    status_t                    status;
    logic                       last;
  } term_rsp_t;

  // Classified operation handed from the front end to the table engine.
  typedef struct packed {
    op_t                op;
    logic [EXP_W-1:0]   exp;
    logic [COEFF_W-1:0] coeff;
  } job_t;

  typedef struct packed {
    logic [EXP_W-1:0]   exp;
    logic [COEFF_W-1:0] coeff;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_PLACE,
    BK_SHIFT,
    BK_PUT,
    BK_DUMP,
    BK_RESP
  } back_state_t;

endpackage

/* rtl/spta_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Small FIFO that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module spta_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spta_pkg::job_t    push_job,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output spta_pkg::job_t    pop_job
);

  spta_pkg::job_t                entries [spta_pkg::QUEUE_DEPTH];
  logic [spta_pkg::QPTR_W-1:0]   wr_ptr;
  logic [spta_pkg::QPTR_W-1:0]   rd_ptr;
  logic [spta_pkg::QCNT_W-1:0]   fill;

  logic do_push;
  logic do_pop;

  assign full      = (fill == spta_pkg::QCNT_W'(spta_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + spta_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + spta_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + spta_pkg::QCNT_W'(1);
        2'b01:   fill <= fill - spta_pkg::QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* rtl/spta_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, forms the term to insert and registers it for the queue.
// ----------------------------------------------------------------------------
module spta_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  spta_pkg::term_req_t   cmd,
  output logic                  push,
  output spta_pkg::job_t        push_job,
  input  logic                  queue_full
);

  logic                          held;
  spta_pkg::job_t                job;
  spta_pkg::job_t                job_next;
  logic [spta_pkg::COEFF_W-1:0]  prod;
  logic                          accept;

  // Low word of the product is the same for signed and unsigned operands.
  assign prod = spta_pkg::COEFF_W'(cmd.coeff_a * cmd.coeff_b);

  always_comb begin
    job_next.op = cmd.operation;
    if (cmd.operation == spta_pkg::OP_ADD_PROD) begin
      job_next.exp   = spta_pkg::EXP_W'(cmd.exp_a) + spta_pkg::EXP_W'(cmd.exp_b);
      job_next.coeff = prod;
    end else begin
      job_next.exp   = spta_pkg::EXP_W'(cmd.exp_a);
      job_next.coeff = cmd.coeff_a;
    end
  end

  assign cmd_stall = held && queue_full;
  assign accept    = cmd_valid && !cmd_stall;
  assign push      = held;
  assign push_job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (!queue_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

/* rtl/spta_back.sv */
// ----------------------------------------------------------------------------
// Table engine
// Runs jobs against the sorted term memory and drives the result register.
// ----------------------------------------------------------------------------
module spta_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  spta_pkg::job_t        job_in,
  output logic                  job_pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output spta_pkg::term_rsp_t   res
);

  localparam int IW = spta_pkg::IDX_W;
  localparam int CW = spta_pkg::CNT_W;

  spta_pkg::entry_t  mem [spta_pkg::MAX_TERMS];
  spta_pkg::entry_t  rdata;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  spta_pkg::entry_t  mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;

  spta_pkg::back_state_t        state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [CW-1:0]                pos, pos_next;
  logic [IW-1:0]                idx, idx_next;
  logic [IW-1:0]                j, j_next;
  logic [spta_pkg::EXP_W-1:0]   jexp, jexp_next;
  logic [spta_pkg::COEFF_W-1:0] jcoeff, jcoeff_next;
  spta_pkg::status_t            status, status_next;

  logic                 out_free;
  logic                 out_load;
  spta_pkg::term_rsp_t  out_next;

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spta_pkg::BK_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    idx    <= idx_next;
    j      <= j_next;
    jexp   <= jexp_next;
    jcoeff <= jcoeff_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= out_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    idx_next    = idx;
    j_next      = j;
    jexp_next   = jexp;
    jcoeff_next = jcoeff;
    status_next = status;
    job_pop     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = rdata;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    out_load    = 1'b0;
    out_next.out_exp    = '0;
    out_next.out_coeff  = '0;
    out_next.term_count = spta_pkg::TCOUNT_W'(count);
    out_next.status     = status;
    out_next.last       = 1'b1;

    case (state)
      spta_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop     = 1'b1;
          jexp_next   = job_in.exp;
          jcoeff_next = job_in.coeff;
          status_next = spta_pkg::ST_OK;
          pos_next    = '0;
          idx_next    = '0;
          case (job_in.op)
            spta_pkg::OP_CLEAR: begin
              count_next = '0;
              state_next = spta_pkg::BK_RESP;
            end
            spta_pkg::OP_DUMP: begin
              if (count == '0) begin
                status_next = spta_pkg::ST_EMPTY;
                state_next  = spta_pkg::BK_RESP;
              end else begin
                mem_re     = 1'b1;
                state_next = spta_pkg::BK_DUMP;
              end
            end
            default: begin
              if (count == '0) begin
                state_next = spta_pkg::BK_PUT;
              end else begin
                mem_re     = 1'b1;
                state_next = spta_pkg::BK_SEARCH;
              end
            end
          endcase
        end
      end

      // rdata holds the entry at pos.
      spta_pkg::BK_SEARCH: begin
        if (rdata.exp == jexp) begin
          mem_we          = 1'b1;
          mem_waddr       = pos[IW-1:0];
          mem_wdata.exp   = rdata.exp;
          mem_wdata.coeff = rdata.coeff + jcoeff;
          state_next      = spta_pkg::BK_RESP;
        end else if (rdata.exp > jexp) begin
          pos_next = pos + CW'(1);
          if (pos + CW'(1) < count) begin
            mem_re    = 1'b1;
            mem_raddr = IW'(pos + CW'(1));
          end else begin
            state_next = spta_pkg::BK_PLACE;
          end
        end else begin
          state_next = spta_pkg::BK_PLACE;
        end
      end

      spta_pkg::BK_PLACE: begin
        if (count == CW'(spta_pkg::MAX_TERMS)) begin
          status_next = spta_pkg::ST_FULL;
          state_next  = spta_pkg::BK_RESP;
        end else if (count > pos) begin
          mem_re     = 1'b1;
          mem_raddr  = IW'(count - CW'(1));
          j_next     = IW'(count);
          state_next = spta_pkg::BK_SHIFT;
        end else begin
          state_next = spta_pkg::BK_PUT;
        end
      end

      // Move entry j-1 up to j, reading the next one down in the same cycle.
      spta_pkg::BK_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = rdata;
        j_next    = j - IW'(1);
        if (CW'(j) > pos + CW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = j - IW'(2);
        end else begin
          state_next = spta_pkg::BK_PUT;
        end
      end

      spta_pkg::BK_PUT: begin
        mem_we          = 1'b1;
        mem_waddr       = pos[IW-1:0];
        mem_wdata.exp   = jexp;
        mem_wdata.coeff = jcoeff;
        count_next      = count + CW'(1);
        state_next      = spta_pkg::BK_RESP;
      end

      spta_pkg::BK_DUMP: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_next.out_exp   = rdata.exp;
          out_next.out_coeff = rdata.coeff;
          out_next.status    = spta_pkg::ST_OK;
          out_next.last      = (CW'(idx) + CW'(1) == count);
          if (CW'(idx) + CW'(1) == count) begin
            state_next = spta_pkg::BK_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx + IW'(1);
            idx_next  = idx + IW'(1);
          end
        end
      end

      spta_pkg::BK_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = spta_pkg::BK_IDLE;
        end
      end

      default: begin
        state_next = spta_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sparse_polynomial_term_accumulator_top.sv */
// ----------------------------------------------------------------------------
// Sparse polynomial term accumulator
// Sorted term table with clear, add term, add product and dump operations.
// ----------------------------------------------------------------------------
// The block holds up to MAX_TERMS terms (exponent, coefficient) sorted by
// strictly descending exponent in a single-port-write, registered-read term
// memory. Each request on the cmd channel is one transaction; clear, add term
// and add product each return one result transaction with last set, and a
// dump returns one result per stored term (last on the final one) or a
// single empty status result. Coefficients wrap to 32 bits and zero
// coefficients stay in the table; a new exponent that finds the table full is
// dropped with status full, while a matching exponent still combines.
// Timing: the front end takes a request per cycle while the two-entry queue
// has room, so requests are taken while the table engine is busy. The engine
// handles one job at a time, stepping the term memory one entry per cycle (a
// dump only while the result side does not stall): an add that stores a new
// exponent searches down to its sorted position, shifts the entries below it
// and then writes the new entry; an add that combines updates the matching
// entry once the search reaches it, and a drop on a full table ends after the
// search; a clear or empty dump goes straight to its result. The memory port
// is used once per cycle by the search, shift and dump sequences. No clearing
// pass is run after reset: only entries below the term count are ever read.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_accumulator_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  spta_pkg::term_req_t   cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output spta_pkg::term_rsp_t   res
);

  logic            push;
  spta_pkg::job_t  push_job;
  logic            queue_full;
  logic            job_valid;
  logic            job_pop;
  spta_pkg::job_t  job;

  // Classify the request and form the exponent and coefficient to insert.
  spta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  // Hold pending jobs so the front end keeps taking requests.
  spta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_job   (job)
  );

  // Walk the term memory and drive the result register.
  spta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_in    (job),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* rtl/spta_checker.sv */
// ----------------------------------------------------------------------------
// Accumulator port checker
// Concurrent checks on the result channel of the accumulator top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spta_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  spta_pkg::term_rsp_t   res
);

  `CHK_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

  `CHK_IMPLY(a_empty_dump, clk, rst, res_valid && (res.status == spta_pkg::ST_EMPTY), (res.term_count == '0) && res.last, "empty status with terms or not last")

  `CHK_IMPLY(a_mid_dump_ok, clk, rst, res_valid && !res.last, res.status == spta_pkg::ST_OK, "non-final result without ok status")

  `CHK_IMPLY(a_no_term_on_error, clk, rst, res_valid && (res.status != spta_pkg::ST_OK), (res.out_exp == '0) && (res.out_coeff == '0), "term data on error status")

endmodule

bind sparse_polynomial_term_accumulator_top spta_checker u_spta_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse polynomial term accumulator testbench
// Drives clear, add term, add product and dump transactions, predicts the
// sorted term table in a scoreboard and checks every result field, with
// random idling on both channels and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT     = 5000;  // cycles with no transaction at all
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 150;   // longest add plus a full dump
  localparam int REPORT_LIMIT    = 10;

  // Mirror of the term table: predicts results and keeps the ones still owed.
  class term_table_tracker;
    logic [spta_pkg::EXP_W-1:0]   exps   [spta_pkg::MAX_TERMS];
    logic [spta_pkg::COEFF_W-1:0] coeffs [spta_pkg::MAX_TERMS];
    int unsigned                  held;
    spta_pkg::term_rsp_t          awaited[$];
    int unsigned                  mismatches;
    int unsigned                  results_seen;
    int unsigned                  full_drops;
    int unsigned                  empty_dumps;
    int unsigned                  dumped_terms;

    function new();
      held = 0;
      mismatches = 0;
      results_seen = 0;
      full_drops = 0;
      empty_dumps = 0;
      dumped_terms = 0;
    endfunction

    function void push_result(logic [spta_pkg::EXP_W-1:0] e,
                              logic [spta_pkg::COEFF_W-1:0] c,
                              spta_pkg::status_t st, logic lst);
      spta_pkg::term_rsp_t r;
      r.out_exp    = e;
      r.out_coeff  = c;
      r.term_count = spta_pkg::TCOUNT_W'(held);
      r.status     = st;
      r.last       = lst;
      awaited.push_back(r);
    endfunction

    // Sorted insert; an equal exponent combines even when the table is full.
    function spta_pkg::status_t place_term(logic [spta_pkg::EXP_W-1:0] e,
                                           logic [spta_pkg::COEFF_W-1:0] c);
      int unsigned pos;
      int unsigned j;
      pos = 0;
      while (pos < held && exps[pos] > e) pos++;
      if (pos < held && exps[pos] == e) begin
        coeffs[pos] = coeffs[pos] + c;
        return spta_pkg::ST_OK;
      end
      if (held >= spta_pkg::MAX_TERMS) begin
        full_drops++;
        return spta_pkg::ST_FULL;
      end
      for (j = held; j > pos; j--) begin
        exps[j]   = exps[j-1];
        coeffs[j] = coeffs[j-1];
      end
      exps[pos]   = e;
      coeffs[pos] = c;
      held++;
      return spta_pkg::ST_OK;
    endfunction

    function void note_command(spta_pkg::term_req_t req);
      spta_pkg::status_t            st;
      logic [spta_pkg::EXP_W-1:0]   e;
      logic [spta_pkg::COEFF_W-1:0] p;
      int unsigned                  i;
      case (req.operation)
        spta_pkg::OP_CLEAR: begin
          held = 0;
          push_result('0, '0, spta_pkg::ST_OK, 1'b1);
        end
        spta_pkg::OP_ADD_TERM: begin
          st = place_term({1'b0, req.exp_a}, req.coeff_a);
          push_result('0, '0, st, 1'b1);
        end
        spta_pkg::OP_ADD_PROD: begin
          e  = {1'b0, req.exp_a} + {1'b0, req.exp_b};
          p  = req.coeff_a * req.coeff_b;
          st = place_term(e, p);
          push_result('0, '0, st, 1'b1);
        end
        default: begin
          if (held == 0) begin
            empty_dumps++;
            push_result('0, '0, spta_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (i = 0; i < held; i++) begin
              push_result(exps[i], coeffs[i], spta_pkg::ST_OK, (i + 1 == held));
              dumped_terms++;
            end
          end
        end
      endcase
    endfunction

    function void log_failure(string note, spta_pkg::term_rsp_t want,
                              spta_pkg::term_rsp_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: %s: expected exp=%0d coeff=%0d count=%0d status=%0d last=%0d",
                 $realtime, note, want.out_exp, want.out_coeff, want.term_count,
                 want.status, want.last);
        $display("    got exp=%0d coeff=%0d count=%0d status=%0d last=%0d",
                 got.out_exp, got.out_coeff, got.term_count, got.status, got.last);
      end
    endfunction

    function void check_result(spta_pkg::term_rsp_t got);
      spta_pkg::term_rsp_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        log_failure("result with nothing owed", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.out_exp !== want.out_exp || got.out_coeff !== want.out_coeff ||
          got.term_count !== want.term_count || got.status !== want.status ||
          got.last !== want.last)
        log_failure("result mismatch", want, got);
    endfunction

    // Exponent already in the table, for combining on a full table.
    function logic [spta_pkg::EXP_W-1:0] stored_exp(int unsigned pick);
      if (held == 0) return '0;
      return exps[pick % held];
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  spta_pkg::term_req_t cmd = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  spta_pkg::term_rsp_t res;

  term_table_tracker book = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_pending = 1'b0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  sparse_polynomial_term_accumulator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the rising edge: book accepted commands first so
  // that a result can never overtake its own expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) book.note_command(cmd);
      if (res_valid && !res_stall) book.check_result(res);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: stall at random, or hold off for a long stretch on request
  // so that the engine and the command queue fill up behind it.
  initial begin
    int k;
    bit hold_off_done;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending && !hold_off_done) begin
        hold_off_done = 1'b1;
        for (k = 0; k < HOLD_OFF_CYCLES; k++) begin
          res_stall <= 1'b1;
          @(negedge clk);
        end
      end
      res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic spta_pkg::term_req_t make_req(spta_pkg::op_t op, int unsigned ea,
                                                   logic [31:0] ca, int unsigned eb,
                                                   logic [31:0] cb);
    spta_pkg::term_req_t r;
    r.operation = op;
    r.exp_a     = spta_pkg::EXP_IN_W'(ea);
    r.coeff_a   = ca;
    r.exp_b     = spta_pkg::EXP_IN_W'(eb);
    r.coeff_b   = cb;
    return r;
  endfunction

  // Offer one transaction from a falling edge and hold it until taken;
  // return at the falling edge after acceptance.
  task automatic drive_command(input spta_pkg::term_req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= req;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Operand fields that clear and dump ignore still carry random bits.
  task automatic drive_plain(input spta_pkg::op_t op);
    drive_command(make_req(op, $urandom_range(0, 32767), $urandom,
                           $urandom_range(0, 32767), $urandom));
  endtask

  task automatic run_directed();
    drive_plain(spta_pkg::OP_DUMP);                                 // empty table
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 0, 32'h8000_0000, 0, 0));
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 32767, 32'h7fff_ffff,
                           32767, 32'hffff_ffff));
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 32767, 32'd1, 0, 0));  // wraps to min
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 0, 32'h8000_0000, 0, 0));  // zero, kept
    drive_command(make_req(spta_pkg::OP_ADD_PROD, 32767, 32'h8000_0000,
                           32767, 32'h8000_0000));
    drive_command(make_req(spta_pkg::OP_ADD_PROD, 16383, 32'hffff_ffff,
                           16384, 32'hffff_ffff));
    drive_command(make_req(spta_pkg::OP_ADD_PROD, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff));
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 21845, 32'h5555_5555,
                           10922, 32'haaaa_aaaa));
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 10922, 32'haaaa_aaaa,
                           21845, 32'h5555_5555));
    drive_command(make_req(spta_pkg::OP_ADD_PROD, 10922, 32'h5555_5555,
                           21845, 32'haaaa_aaaa));
    drive_plain(spta_pkg::OP_DUMP);
    drive_plain(spta_pkg::OP_CLEAR);
    drive_plain(spta_pkg::OP_DUMP);                                 // empty after clear
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 100, 32'd7, 0, 0));
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 300, 32'd9, 0, 0));
    drive_command(make_req(spta_pkg::OP_ADD_TERM, 200, -32'sd5, 0, 0));  // in the middle
    drive_command(make_req(spta_pkg::OP_ADD_PROD, 150, 32'd3, 150, 32'd4));  // with 300
    drive_plain(spta_pkg::OP_DUMP);
    drive_plain(spta_pkg::OP_CLEAR);
  endtask

  // Clear, then add enough distinct exponents to overflow the table; past the
  // capacity, mix new exponents (dropped) with stored ones (still combine).
  task automatic run_fill_episode();
    int unsigned n;
    int unsigned k;
    int unsigned e;
    drive_plain(spta_pkg::OP_CLEAR);
    n = $urandom_range(36, 42);
    for (k = 0; k < n; k++) begin
      if (k >= spta_pkg::MAX_TERMS && $urandom_range(0, 1) == 1) begin
        e = 32'(book.stored_exp($urandom));
        drive_command(make_req(spta_pkg::OP_ADD_PROD, e >> 1, $urandom,
                               e - (e >> 1), $urandom));
      end else if ($urandom_range(0, 3) == 0) begin
        drive_command(make_req(spta_pkg::OP_ADD_PROD, $urandom_range(0, 32767), $urandom,
                               $urandom_range(0, 32767), $urandom));
      end else begin
        drive_command(make_req(spta_pkg::OP_ADD_TERM, $urandom_range(0, 32767), $urandom,
                               $urandom_range(0, 32767), $urandom));
      end
    end
    drive_plain(spta_pkg::OP_DUMP);
  endtask

  // Optionally a clear, then a few adds, often from a narrow exponent range so that terms combine, then a dump.
  task automatic run_short_episode();
    int unsigned n;
    int unsigned k;
    bit          wide;
    wide = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1) == 1) drive_plain(spta_pkg::OP_CLEAR);
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0)
        drive_command(make_req(spta_pkg::OP_ADD_PROD,
                               wide ? $urandom_range(0, 32767) : $urandom_range(0, 6),
                               $urandom,
                               wide ? $urandom_range(0, 32767) : $urandom_range(0, 6),
                               $urandom));
      else
        drive_command(make_req(spta_pkg::OP_ADD_TERM,
                               wide ? $urandom_range(0, 32767) : $urandom_range(0, 12),
                               $urandom, $urandom_range(0, 32767), $urandom));
    end
    drive_plain(spta_pkg::OP_DUMP);
  endtask

  // Fully random transactions, any operation in any order.
  task automatic run_noise_episode();
    int unsigned n;
    int unsigned k;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++)
      drive_command(make_req(spta_pkg::op_t'($urandom_range(0, 3)),
                             $urandom_range(0, 32767), $urandom,
                             $urandom_range(0, 32767), $urandom));
  endtask

  task automatic run_random_phase(input int unsigned count, input bit with_fill);
    int unsigned stop_at;
    stop_at = items_sent + count;
    if (with_fill) run_fill_episode();
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) run_noise_episode();
      else run_short_episode();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Slow sender, heavily stalled receiver.
    send_idle_pct = 35;
    recv_idle_pct = 88;
    run_directed();
    run_random_phase(45, 1'b1);

    // Swap: sparse sender, mostly ready receiver.
    send_idle_pct = 88;
    recv_idle_pct = 35;
    run_random_phase(45, 1'b0);

    // Full rate, opening with a long result hold-off to back up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_pending = 1'b1;
    run_random_phase(45, 1'b1);

    cmd_valid <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d results: %0d dumped terms, %0d empty dumps,",
             items_sent, book.results_seen, book.dumped_terms, book.empty_dumps);
    $display("%0d adds dropped on a full table, %0d failures.",
             book.full_drops, book.mismatches + book.awaited.size());
    if (book.mismatches == 0 && book.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sparse_polynomial_term_accumulator_top.f */
+incdir+rtl
rtl/spta_pkg.sv
rtl/spta_queue.sv
rtl/spta_front.sv
rtl/spta_back.sv
rtl/sparse_polynomial_term_accumulator_top.sv
rtl/spta_checker.sv
bench/tb.sv
